@@ rtl/hsp_pkg.sv @@
// hsp_pkg: shared types and constants of the hall sensor position counter
// used by every module of the block, depends on nothing

`timescale 1ns / 1ps

package hsp_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned CfgAddrWidth = 3;
  localparam logic [15:0] CountsPerRevReset = 16'd4096;

  // register indexes, decoded from paddr[2]
  localparam logic RegCountsPerRev = 1'b0;
  localparam logic RegCountInverted = 1'b1;

  // channel codes, in scan order
  localparam logic [1:0] ChanA = 2'd0;
  localparam logic [1:0] ChanB = 2'd1;
  localparam logic [1:0] ChanC = 2'd2;

  localparam logic signed [1:0] DirNone = 2'sd0;
  localparam logic signed [1:0] DirFwd = 2'sd1;
  localparam logic signed [1:0] DirBwd = -2'sd1;

  typedef struct packed {
    logic [CountWidth-1:0] counts_per_rev;
    logic                  count_inverted;
  } cfg_t;

  typedef struct packed {
    logic [2:0]            level_code;
    logic signed [1:0]     direction;
    logic                  changed;
    logic [CountWidth-1:0] position;
  } result_t;

endpackage

@@ rtl/hall_sensor_position_counter_unit.sv @@
// hall_sensor_position_counter_unit: top level of the hall sensor position counter
// depends on hsp_pkg, hsp_regs and hsp_core

`timescale 1ns / 1ps

// Decodes three hall sensor channel levels into a position within one revolution.
// Every accepted sample gives exactly one result: position, changed flag, last
// direction and the stored level code. A sample is taken into an input register,
// the decoder state and result are worked out in one pass and caught in an output
// register, so one sample a cycle is sustained while the output is not stalled.
// Counts per revolution and inversion are set over apb at byte addresses 0 and 4;
// the user must write them only while idle, which the block does not enforce.

module hall_sensor_position_counter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // level_a, level_b, level_c, zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // position[15:0], changed, direction[1:0], level_code[2:0], zero fill
);

  hsp_pkg::cfg_t    cfg;
  hsp_pkg::result_t result;
  hsp_pkg::result_t out_result;

  logic       in_valid;
  logic [2:0] in_levels;
  logic       advance;

  assign advance = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | advance;

  hsp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hsp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .levels  (in_levels),
    .advance (advance),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tvalid & s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid & s_tready) begin
      in_levels <= s_tdata[2:0];
    end
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tdata = {2'b00, out_result.level_code, out_result.direction,
                    out_result.changed, out_result.position};

endmodule

@@ rtl/hsp_regs.sv @@
// hsp_regs: apb register file for counts per revolution and count inversion
// depends on hsp_pkg

`timescale 1ns / 1ps

module hsp_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hsp_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output hsp_pkg::cfg_t                    cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.counts_per_rev <= hsp_pkg::CountsPerRevReset;
      cfg.count_inverted <= 1'b0;
    end else if (wr_en) begin
      case (paddr[2])
        hsp_pkg::RegCountsPerRev: cfg.counts_per_rev <= pwdata[15:0];
        hsp_pkg::RegCountInverted: cfg.count_inverted <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      hsp_pkg::RegCountsPerRev: prdata = {16'd0, cfg.counts_per_rev};
      hsp_pkg::RegCountInverted: prdata = {31'd0, cfg.count_inverted};
      default: prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/hsp_core.sv @@
// hsp_core: decoder state and the single-pass update for one level sample
// depends on hsp_pkg

`timescale 1ns / 1ps

module hsp_core (
  input  logic            clk,
  input  logic            rst,
  input  hsp_pkg::cfg_t   cfg,
  input  logic [2:0]      levels,
  input  logic            advance,
  output hsp_pkg::result_t result
);

  localparam int unsigned W = hsp_pkg::CountWidth;

  logic [2:0]        stored_levels, stored_levels_next;
  logic [1:0]        last_channel, last_channel_next;
  logic              last_channel_valid, last_channel_valid_next;
  logic [W-1:0]      count_value, count_value_next;
  logic signed [1:0] last_direction, last_direction_next;

  logic [2:0]   diff;
  logic [1:0]   chan;
  logic         fwd_seq;
  logic         step_fwd;
  logic [W:0]   modulus;
  logic [W:0]   top_value;
  logic [W:0]   count_ext;
  logic [W-1:0] fwd_value;
  logic [W-1:0] bwd_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_levels <= 3'd0;
      last_channel <= hsp_pkg::ChanA;
      last_channel_valid <= 1'b0;
      count_value <= '0;
      last_direction <= hsp_pkg::DirNone;
    end else if (advance) begin
      stored_levels <= stored_levels_next;
      last_channel <= last_channel_next;
      last_channel_valid <= last_channel_valid_next;
      count_value <= count_value_next;
      last_direction <= last_direction_next;
    end
  end

  always_comb begin
    diff = levels ^ stored_levels;
    if (diff[0]) begin
      chan = hsp_pkg::ChanA;
    end else if (diff[1]) begin
      chan = hsp_pkg::ChanB;
    end else begin
      chan = hsp_pkg::ChanC;
    end

    case (last_channel)
      hsp_pkg::ChanA: fwd_seq = (chan == hsp_pkg::ChanB);
      hsp_pkg::ChanB: fwd_seq = (chan == hsp_pkg::ChanC);
      hsp_pkg::ChanC: fwd_seq = (chan == hsp_pkg::ChanA);
      default: fwd_seq = 1'b0;
    endcase
    step_fwd = fwd_seq ^ cfg.count_inverted;

    // zero counts per revolution wraps in the full count width
    modulus = (cfg.counts_per_rev == '0) ? {1'b1, {W{1'b0}}} : {1'b0, cfg.counts_per_rev};
    top_value = modulus - 1'b1;
    count_ext = {1'b0, count_value};
    fwd_value = (count_ext >= top_value) ? '0 : count_value + 1'b1;
    bwd_value = ((count_value == '0) || (count_ext >= modulus)) ? top_value[W-1:0]
                                                                : count_value - 1'b1;

    stored_levels_next = stored_levels;
    last_channel_next = last_channel;
    last_channel_valid_next = last_channel_valid;
    count_value_next = count_value;
    last_direction_next = last_direction;
    if (diff != 3'd0) begin
      stored_levels_next = levels;
      last_channel_next = chan;
      last_channel_valid_next = 1'b1;
      if (last_channel_valid) begin
        count_value_next = step_fwd ? fwd_value : bwd_value;
        last_direction_next = step_fwd ? hsp_pkg::DirFwd : hsp_pkg::DirBwd;
      end
    end

    result.position = count_value_next;
    result.changed = (count_value_next != count_value);
    result.direction = last_direction_next;
    result.level_code = stored_levels_next;
  end

endmodule
